/* rtl/bra_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Request and response types, command kinds, status codes and defaults
// shared by the allocator modules.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int HEAP_SLOTS_DEF = 64;
  localparam int HEAP_COUNT_DEF = 4;

  // Slots examined per scan cycle, and the width of one bitmap word.
  localparam int SCAN_LANES  = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_BADLEN = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [6:0] run_length;
    logic [7:0] free_start;
  } bra_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] start_slot;
    logic [1:0] heap_number;
    logic [5:0] slot_in_heap;
  } bra_out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] len;
    logic [7:0] lo;
  } bra_cmd_t;

endpackage

/* rtl/bra_front.sv */
// ----------------------------------------------------------------------------
// Allocator front end
// Takes requests, sorts them into allocate, free and bad-length commands and
// hands them to the command queue through a one-entry holding register.
// ----------------------------------------------------------------------------
module bra_front #(
  parameter int HEAP_SLOTS = bra_pkg::HEAP_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bra_pkg::bra_in_t   in_req,
  input  logic               q_full,
  output logic               push,
  output bra_pkg::bra_cmd_t  push_cmd
);
  import bra_pkg::*;

  logic     vld_r, vld_nxt;
  bra_cmd_t cmd_r;
  bra_cmd_t cmd_cls;
  logic     accept;

  always_comb begin
    cmd_cls.len = in_req.run_length;
    cmd_cls.lo  = in_req.free_start;
    priority if (in_req.opcode == OP_FREE) begin
      cmd_cls.kind = KIND_FREE;
    end else if (in_req.run_length == 7'd0 ||
                 32'(in_req.run_length) > 32'(HEAP_SLOTS)) begin
      cmd_cls.kind = KIND_BADLEN;
    end else begin
      cmd_cls.kind = KIND_ALLOC;
    end
  end

  assign busy     = vld_r & q_full;
  assign accept   = start & ~busy;
  assign push     = vld_r & ~q_full;
  assign push_cmd = cmd_r;
  assign vld_nxt  = accept | (vld_r & q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_cls;
    end
  end

endmodule

/* rtl/bra_queue.sv */
// ----------------------------------------------------------------------------
// Allocator command queue
// Short FIFO between the front end and the bitmap engine so that each side
// can stall on its own.
// ----------------------------------------------------------------------------
module bra_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bra_pkg::bra_cmd_t  push_cmd,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output bra_pkg::bra_cmd_t  rd_cmd
);
  import bra_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

  bra_cmd_t        q_mem [QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_cmd  = q_mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == LAST_P) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == LAST_P) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wp_r] <= push_cmd;
    end
  end

endmodule

/* rtl/bra_back.sv */
// ----------------------------------------------------------------------------
// Allocator bitmap engine
// Owns the occupancy bitmap. Runs the first-fit scan a word per cycle, sets or
// clears a run a word per cycle, splits the start slot into heap and offset,
// and drives the one-cycle response strobe.
// ----------------------------------------------------------------------------
module bra_back #(
  parameter int HEAP_SLOTS = bra_pkg::HEAP_SLOTS_DEF,
  parameter int HEAP_COUNT = bra_pkg::HEAP_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  bra_pkg::bra_cmd_t  q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  output bra_pkg::bra_out_t  out_rsp
);
  import bra_pkg::*;

  localparam int TOTAL = HEAP_SLOTS * HEAP_COUNT;
  localparam int WORDS = (TOTAL + SCAN_LANES - 1) / SCAN_LANES;
  localparam int SW    = $clog2(TOTAL);
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LB    = $clog2(SCAN_LANES);
  localparam int RW    = ((SW > 8) ? SW : 8) + 1;
  localparam int HCW   = (HEAP_COUNT > 1) ? $clog2(HEAP_COUNT) : 1;
  localparam logic [RW-1:0]  TOTAL_R  = RW'(TOTAL);
  localparam logic [RW-1:0]  LANES_R  = RW'(SCAN_LANES);
  localparam logic [WIW-1:0] LAST_W   = WIW'(WORDS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [SCAN_LANES-1:0] map_r [WORDS];
  logic [SCAN_LANES-1:0] word, mask, wdata;
  logic                  map_we;

  logic [1:0]     state_r, state_nxt;
  logic [WIW-1:0] wi_r, wi_nxt;
  logic [6:0]     len_r, len_nxt;
  logic [6:0]     cnt_r, cnt_nxt;
  logic [SW-1:0]  rstart_r, rstart_nxt;
  logic [RW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic           set_r, set_nxt;
  logic [SW-1:0]  rem_r, rem_nxt;
  logic [HCW-1:0] heap_r, heap_nxt;
  logic           out_valid_r, out_valid_nxt;
  bra_out_t       out_rsp_r, out_rsp_nxt;

  logic [6:0]     scan_cnt;
  logic [SW-1:0]  scan_start;
  logic           scan_hit;
  logic [RW-1:0]  word_base, next_base, lo_ext;

  assign word      = map_r[wi_r];
  assign word_base = RW'({wi_r, LB'(0)});
  assign next_base = word_base + LANES_R;
  assign lo_ext    = RW'(q_cmd.lo);

  // First-fit scan over one word: the free-run count carries across words.
  always_comb begin
    logic [RW-1:0] pos;
    logic          free_b;
    scan_cnt   = cnt_r;
    scan_start = rstart_r;
    scan_hit   = 1'b0;
    for (int b = 0; b < SCAN_LANES; b++) begin
      pos    = word_base + RW'(b);
      free_b = ~word[b] & (pos < TOTAL_R);
      if (!scan_hit) begin
        if (!free_b) begin
          scan_cnt = '0;
        end else begin
          if (scan_cnt == '0) begin
            scan_start = SW'(pos);
          end
          scan_cnt = scan_cnt + 7'd1;
          if (scan_cnt == len_r) begin
            scan_hit = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    logic [RW-1:0] pos;
    for (int b = 0; b < SCAN_LANES; b++) begin
      pos     = word_base + RW'(b);
      mask[b] = (pos >= lo_r) & (pos < hi_r) & (pos < TOTAL_R);
    end
    wdata = set_r ? (word | mask) : (word & ~mask);
  end

  always_comb begin
    state_nxt     = state_r;
    wi_nxt        = wi_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    rstart_nxt    = rstart_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    set_nxt       = set_r;
    rem_nxt       = rem_r;
    heap_nxt      = heap_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = '0;
    q_pop         = 1'b0;
    map_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          len_nxt = q_cmd.len;
          unique case (q_cmd.kind)
            KIND_BADLEN: begin
              out_valid_nxt      = 1'b1;
              out_rsp_nxt.status = ST_BADLEN;
            end
            KIND_FREE: begin
              if (q_cmd.len == 7'd0 || lo_ext >= TOTAL_R) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = ST_OK;
              end else begin
                lo_nxt    = lo_ext;
                hi_nxt    = lo_ext + RW'(q_cmd.len);
                set_nxt   = 1'b0;
                wi_nxt    = WIW'(lo_ext >> LB);
                state_nxt = S_MARK;
              end
            end
            default: begin
              wi_nxt    = '0;
              cnt_nxt   = '0;
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        cnt_nxt    = scan_cnt;
        rstart_nxt = scan_start;
        if (scan_hit) begin
          lo_nxt    = RW'(scan_start);
          hi_nxt    = RW'(scan_start) + RW'(len_r);
          set_nxt   = 1'b1;
          wi_nxt    = WIW'(scan_start >> LB);
          rem_nxt   = scan_start;
          heap_nxt  = '0;
          state_nxt = S_MARK;
        end else if (wi_r == LAST_W) begin
          out_valid_nxt      = 1'b1;
          out_rsp_nxt.status = ST_NOFIT;
          state_nxt          = S_IDLE;
        end else begin
          wi_nxt = wi_r + WIW'(1);
        end
      end
      S_MARK: begin
        map_we = 1'b1;
        if (wi_r == LAST_W || next_base >= hi_r) begin
          if (set_r) begin
            state_nxt = S_DIV;
          end else begin
            out_valid_nxt      = 1'b1;
            out_rsp_nxt.status = ST_OK;
            state_nxt          = S_IDLE;
          end
        end else begin
          wi_nxt = wi_r + WIW'(1);
        end
      end
      default: begin
        // Heap split by repeated subtraction, one heap per cycle.
        if (32'(rem_r) >= 32'(HEAP_SLOTS)) begin
          rem_nxt  = rem_r - SW'(HEAP_SLOTS);
          heap_nxt = heap_r + HCW'(1);
        end else begin
          out_valid_nxt            = 1'b1;
          out_rsp_nxt.status       = ST_OK;
          out_rsp_nxt.start_slot   = 8'(lo_r);
          out_rsp_nxt.heap_number  = 2'(heap_r);
          out_rsp_nxt.slot_in_heap = 6'(rem_r);
          state_nxt                = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int w = 0; w < WORDS; w++) begin
        map_r[w] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (map_we) begin
        map_r[wi_r] <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    wi_r      <= wi_nxt;
    len_r     <= len_nxt;
    cnt_r     <= cnt_nxt;
    rstart_r  <= rstart_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    set_r     <= set_nxt;
    rem_r     <= rem_nxt;
    heap_r    <= heap_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTHESIS
  // A scan that is still running has not yet found a long enough run.
  a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r < len_r)
    else $error("free-run count reached the length without ending the scan");

  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MARK |-> hi_r > lo_r && lo_r < TOTAL_R)
    else $error("run being marked is empty or starts past the bitmap");

  a_div_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> set_r && 32'(heap_r) < HEAP_COUNT)
    else $error("heap split entered for a free or ran past the last heap");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.status != ST_OK |->
      out_rsp_r.start_slot == '0 && out_rsp_r.heap_number == '0 &&
      out_rsp_r.slot_in_heap == '0)
    else $error("error response carries a nonzero slot");
`endif

endmodule

/* rtl/bitmap_run_allocator.sv */
// ----------------------------------------------------------------------------
// Bitmap run allocator
// First-fit allocator of slot runs over a fixed occupancy bitmap that is
// split into equal heaps.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; each request gives
// exactly one response, shown for one cycle with out_valid high, in request
// order, and the receiver must take it then. A request passes a holding
// register and a two-entry command queue before the bitmap engine, so a few
// requests can be taken while the engine works. The engine handles one
// request at a time and takes the next only when it is back in idle. A bad
// length is answered straight from idle; a free clears each bitmap word
// that it touches (up to 9 words for a 64-slot run); an allocate scans the
// bitmap 8 slots per cycle from slot 0 until it finds the run, then sets
// each touched word and splits off the heap number by repeated subtraction
// of the heap size. A failed allocate scans all 32 words. The bitmap word
// scan sets the rate. After reset every slot is free at once.
// ----------------------------------------------------------------------------
module bitmap_run_allocator #(
  parameter int HEAP_SLOTS = bra_pkg::HEAP_SLOTS_DEF,
  parameter int HEAP_COUNT = bra_pkg::HEAP_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bra_pkg::bra_in_t  in_req,
  output logic              out_valid,
  output bra_pkg::bra_out_t out_rsp
);
  import bra_pkg::*;

  logic     push, q_full, q_empty, q_pop;
  bra_cmd_t push_cmd, q_cmd;

  bra_front #(
    .HEAP_SLOTS(HEAP_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bra_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .empty    (q_empty),
    .pop      (q_pop),
    .rd_cmd   (q_cmd)
  );

  bra_back #(
    .HEAP_SLOTS(HEAP_SLOTS),
    .HEAP_COUNT(HEAP_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

/* tb/sv/bitmap_run_allocator_tb.sv */
// ----------------------------------------------------------------------------
// Bitmap run allocator testbench
// Drives allocate and free requests into the allocator and checks every
// response against a table value or a bitmap predictor kept inside the
// bench. A short table covers length limits, heap crossing, a full map and
// out-of-range frees. Random traffic follows, in which most frees release
// runs that are still held, and it runs under several sender idle patterns.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_tb;
  import bra_pkg::*;

  localparam int HEAP_SLOTS    = HEAP_SLOTS_DEF;
  localparam int HEAP_COUNT    = HEAP_COUNT_DEF;
  localparam int TOTAL_SLOTS   = HEAP_SLOTS * HEAP_COUNT;
  localparam int SIW           = $clog2(TOTAL_SLOTS);
  localparam int NUM_DIRECTED  = 25;
  localparam int PHASE_ITEMS   = 425;
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    bra_in_t  req;
    logic     typed;
    bra_out_t rsp;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  bra_in_t  in_req = '0;
  logic     out_valid;
  bra_out_t out_rsp;

  bit [TOTAL_SLOTS-1:0] slot_used;
  bra_out_t             expected_rsp[$];
  int unsigned          held_base[$];
  int unsigned          held_len[$];
  int                   mismatches = 0;
  int                   cycle_count = 0;

  bitmap_run_allocator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic dir_row_t dir_row(input logic op, input int len, input int fs,
                                       input logic typed, input logic [1:0] st,
                                       input int slot);
    dir_row_t r;
    r.req.opcode        = op;
    r.req.run_length    = 7'(len);
    r.req.free_start    = 8'(fs);
    r.typed             = typed;
    r.rsp.status        = st;
    r.rsp.start_slot    = 8'(slot);
    r.rsp.heap_number   = 2'(slot / HEAP_SLOTS);
    r.rsp.slot_in_heap  = 6'(slot % HEAP_SLOTS);
    return r;
  endfunction

  // Rows with typed = 0 are checked against the predictor only.
  dir_row_t directed [NUM_DIRECTED] = '{
    dir_row(OP_ALLOC,   0,   0, 1'b1, ST_BADLEN,   0),
    dir_row(OP_ALLOC,  65,   0, 1'b1, ST_BADLEN,   0),
    dir_row(OP_ALLOC, 127, 255, 1'b1, ST_BADLEN,   0),
    dir_row(OP_ALLOC,   1,   0, 1'b1, ST_OK,       0),
    dir_row(OP_ALLOC,  64,   0, 1'b1, ST_OK,       1),
    dir_row(OP_ALLOC,  64,   0, 1'b1, ST_OK,      65),
    dir_row(OP_ALLOC,  64,   0, 1'b1, ST_OK,     129),
    dir_row(OP_ALLOC,  64,   0, 1'b1, ST_NOFIT,    0),
    dir_row(OP_ALLOC,  63,   0, 1'b1, ST_OK,     193),
    dir_row(OP_ALLOC,   1,   0, 1'b1, ST_NOFIT,    0),
    dir_row(OP_FREE,  127, 255, 1'b1, ST_OK,       0),
    dir_row(OP_ALLOC,   1,   0, 1'b0, ST_OK,       0),
    dir_row(OP_FREE,    0,   0, 1'b1, ST_OK,       0),
    dir_row(OP_ALLOC,   1,   0, 1'b1, ST_NOFIT,    0),
    dir_row(OP_FREE,   64,   0, 1'b1, ST_OK,       0),
    dir_row(OP_FREE,   64,   0, 1'b1, ST_OK,       0),
    dir_row(OP_ALLOC,  64, 170, 1'b0, ST_OK,       0),
    dir_row(OP_FREE,   10, 100, 1'b1, ST_OK,       0),
    dir_row(OP_ALLOC,  11,   0, 1'b0, ST_OK,       0),
    dir_row(OP_ALLOC,  10,  85, 1'b0, ST_OK,       0),
    dir_row(OP_FREE,    2, 127, 1'b0, ST_OK,       0),
    dir_row(OP_ALLOC,   2,   0, 1'b0, ST_OK,       0),
    dir_row(OP_FREE,  127,   0, 1'b0, ST_OK,       0),
    dir_row(OP_FREE,  127, 127, 1'b0, ST_OK,       0),
    dir_row(OP_FREE,    2, 254, 1'b0, ST_OK,       0)
  };

  // First-fit search over the bitmap, or a clear for a free; updates the map as the block would.
  function automatic bra_out_t first_fit_result(input bra_in_t req);
    bra_out_t    rsp;
    int unsigned len;
    int unsigned base;
    int unsigned k;
    int unsigned slot;
    bit          fits;
    rsp = '0;
    rsp.status = ST_OK;
    len = 32'(req.run_length);
    if (req.opcode == OP_FREE) begin
      for (k = 0; k < len; k++) begin
        slot = 32'(req.free_start) + k;
        if (slot < TOTAL_SLOTS) slot_used[SIW'(slot)] = 1'b0;
      end
      return rsp;
    end
    if (len == 0 || len > HEAP_SLOTS) begin
      rsp.status = ST_BADLEN;
      return rsp;
    end
    for (base = 0; base + len <= TOTAL_SLOTS; base++) begin
      fits = 1'b1;
      for (k = 0; k < len; k++) begin
        if (slot_used[SIW'(base + k)]) fits = 1'b0;
      end
      if (fits) begin
        for (k = 0; k < len; k++) slot_used[SIW'(base + k)] = 1'b1;
        rsp.start_slot   = 8'(base);
        rsp.heap_number  = 2'(base / HEAP_SLOTS);
        rsp.slot_in_heap = 6'(base % HEAP_SLOTS);
        return rsp;
      end
    end
    rsp.status = ST_NOFIT;
    return rsp;
  endfunction

  // Most frees release a run that is still held; the rest are noise.
  function automatic bra_in_t random_req();
    bra_in_t     req;
    int unsigned pick;
    int unsigned idx;
    req.opcode     = OP_ALLOC;
    req.run_length = 7'($urandom_range(1, 8));
    req.free_start = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 32 && held_base.size() > 0) begin
      idx = $urandom_range(held_base.size() - 1);
      req.opcode     = OP_FREE;
      req.free_start = 8'(held_base[idx]);
      req.run_length = 7'(held_len[idx]);
      held_base.delete(idx);
      held_len.delete(idx);
    end else if (pick >= 32 && pick < 40) begin
      req.opcode = OP_FREE;
      req.run_length = ($urandom_range(3) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 15));
    end else if (pick >= 40 && pick < 45) begin
      req.run_length = ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
    end else if (pick >= 45 && pick < 65) begin
      req.run_length = 7'($urandom_range(9, 64));
    end
    return req;
  endfunction

  // Holds the request until the block takes it, then records what it owes.
  task automatic issue_req(input bra_in_t req, input bra_out_t typed_rsp,
                           input logic typed);
    bra_out_t rsp;
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    rsp = first_fit_result(req);
    expected_rsp.push_back(typed ? typed_rsp : rsp);
    if (req.opcode == OP_ALLOC && rsp.status == ST_OK) begin
      held_base.push_back(32'(rsp.start_slot));
      held_len.push_back(32'(req.run_length));
    end
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    bra_out_t exp_rsp;
    if (rst_n && out_valid) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected response: status %0d slot %0d heap %0d index %0d",
                   out_rsp.status, out_rsp.start_slot, out_rsp.heap_number,
                   out_rsp.slot_in_heap);
      end else begin
        exp_rsp = expected_rsp.pop_front();
        if (out_rsp.status !== exp_rsp.status ||
            out_rsp.start_slot !== exp_rsp.start_slot ||
            out_rsp.heap_number !== exp_rsp.heap_number ||
            out_rsp.slot_in_heap !== exp_rsp.slot_in_heap) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("response mismatch: expected status %0d slot %0d heap %0d index %0d,",
                     exp_rsp.status, exp_rsp.start_slot, exp_rsp.heap_number,
                     exp_rsp.slot_in_heap,
                     " got status %0d slot %0d heap %0d index %0d",
                     out_rsp.status, out_rsp.start_slot, out_rsp.heap_number,
                     out_rsp.slot_in_heap);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int idle_pct [4];
    int i;
    int p;
    idle_pct = '{0, 68, 0, 23};
    slot_used = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) begin
      issue_req(directed[i].req, directed[i].rsp, directed[i].typed);
      sender_gap(25);
    end
    // The closing rows empty the map, so nothing from the table is still held.
    held_base.delete();
    held_len.delete();

    for (p = 0; p < 4; p++) begin
      wait_drained();
      for (i = 0; i < PHASE_ITEMS; i++) begin
        issue_req(random_req(), '0, 1'b0);
        sender_gap(idle_pct[p]);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bra_pkg.sv
rtl/bra_front.sv
rtl/bra_queue.sv
rtl/bra_back.sv
rtl/bitmap_run_allocator.sv
tb/sv/bitmap_run_allocator_tb.sv
